FILE: rtl/srrb_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// srrb_pkg: shared types and codes for the session recovery supervisor
// Register map, event and status codes, and the word types carried between
// the register block, the decision engine and the top level.
// ----------------------------------------------------------------------------
package srrb_pkg;

    // configuration port
    localparam int unsigned CFG_ADDR_W = 5;
    localparam int unsigned CFG_DATA_W = 32;
    localparam int unsigned CFG_IDX_W  = 3;

    localparam logic [CFG_IDX_W-1:0] REG_SETTLE_TIME = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FAST_LIMIT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FAST_DELAY  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SLOW_DELAY  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_STABLE_TIME = 3'd4;

    localparam logic [31:0] RST_SETTLE_TIME = 32'd3000;
    localparam logic [7:0]  RST_FAST_LIMIT  = 8'd3;
    localparam logic [31:0] RST_FAST_DELAY  = 32'd5000;
    localparam logic [31:0] RST_SLOW_DELAY  = 32'd60000;
    localparam logic [31:0] RST_STABLE_TIME = 32'd10000;

    // event kinds
    localparam logic [1:0] ACT_PRESENCE = 2'd0;
    localparam logic [1:0] ACT_ATTEMPT  = 2'd1;
    localparam logic [1:0] ACT_OBSERVE  = 2'd2;

    // observed service status
    localparam logic [1:0] STATUS_UNKNOWN = 2'd0;
    localparam logic [1:0] STATUS_ON      = 2'd1;
    localparam logic [1:0] STATUS_OFF     = 2'd2;

    // recovery step answers
    localparam logic [1:0] STEP_WAIT   = 2'd0;
    localparam logic [1:0] STEP_RELOAD = 2'd1;
    localparam logic [1:0] STEP_POLL   = 2'd2;

    typedef struct packed {
        logic [31:0] settle_time;
        logic [7:0]  fast_attempt_limit;
        logic [31:0] fast_retry_delay;
        logic [31:0] slow_retry_delay;
        logic [31:0] stable_time;
    } cfg_t;

    typedef struct packed {
        logic [1:0]  action;
        logic [63:0] now;
        logic        desktop_present;
        logic        session_changed;
        logic        enable_requested;
        logic [1:0]  service_status;
    } item_t;

    typedef struct packed {
        logic [1:0] recovery_step;
        logic       restart_needed;
        logic       attempt_due;
    } result_t;

endpackage
`default_nettype wire

FILE: rtl/srrb_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// srrb_if: event and result channels
// Valid/ready channels; a word moves on a rising edge with valid and ready high.
// ----------------------------------------------------------------------------
interface srrb_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic [63:0] now;
    logic        desktop_present;
    logic        session_changed;
    logic        enable_requested;
    logic [1:0]  service_status;

    modport source (
        output valid, action, now, desktop_present, session_changed,
               enable_requested, service_status,
        input  ready
    );
    modport sink (
        input  valid, action, now, desktop_present, session_changed,
               enable_requested, service_status,
        output ready
    );
endinterface

interface srrb_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] recovery_step;
    logic       restart_needed;
    logic       attempt_due;

    modport source (
        output valid, recovery_step, restart_needed, attempt_due,
        input  ready
    );
    modport sink (
        input  valid, recovery_step, restart_needed, attempt_due,
        output ready
    );
endinterface
`default_nettype wire

FILE: rtl/srrb_cfg_regs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// srrb_cfg_regs: configuration register block
// APB-style slave holding the five timing and limit registers.
// ----------------------------------------------------------------------------
module srrb_cfg_regs (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [srrb_pkg::CFG_ADDR_W-1:0]    paddr,
    input  wire logic [srrb_pkg::CFG_DATA_W-1:0]    pwdata,
    output logic      [srrb_pkg::CFG_DATA_W-1:0]    prdata,
    output logic                                    pready,
    output srrb_pkg::cfg_t                          cfg
);

    srrb_pkg::cfg_t                   cfg_reg;
    logic                             wr_en;
    logic [srrb_pkg::CFG_IDX_W-1:0]   idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = paddr[srrb_pkg::CFG_ADDR_W-1:2];
    assign cfg    = cfg_reg;

    // register write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.settle_time        <= srrb_pkg::RST_SETTLE_TIME;
            cfg_reg.fast_attempt_limit <= srrb_pkg::RST_FAST_LIMIT;
            cfg_reg.fast_retry_delay   <= srrb_pkg::RST_FAST_DELAY;
            cfg_reg.slow_retry_delay   <= srrb_pkg::RST_SLOW_DELAY;
            cfg_reg.stable_time        <= srrb_pkg::RST_STABLE_TIME;
        end
        else if (wr_en)
        begin
            unique case (idx)
                srrb_pkg::REG_SETTLE_TIME: cfg_reg.settle_time        <= pwdata;
                srrb_pkg::REG_FAST_LIMIT:  cfg_reg.fast_attempt_limit <= pwdata[7:0];
                srrb_pkg::REG_FAST_DELAY:  cfg_reg.fast_retry_delay   <= pwdata;
                srrb_pkg::REG_SLOW_DELAY:  cfg_reg.slow_retry_delay   <= pwdata;
                srrb_pkg::REG_STABLE_TIME: cfg_reg.stable_time        <= pwdata;
                default: ;
            endcase
        end
    end

    // read back
    always_comb
    begin
        unique case (idx)
            srrb_pkg::REG_SETTLE_TIME: prdata = cfg_reg.settle_time;
            srrb_pkg::REG_FAST_LIMIT:  prdata = {24'd0, cfg_reg.fast_attempt_limit};
            srrb_pkg::REG_FAST_DELAY:  prdata = cfg_reg.fast_retry_delay;
            srrb_pkg::REG_SLOW_DELAY:  prdata = cfg_reg.slow_retry_delay;
            srrb_pkg::REG_STABLE_TIME: prdata = cfg_reg.stable_time;
            default:                   prdata = '0;
        endcase
    end

endmodule
`default_nettype wire

FILE: rtl/srrb_engine.sv
`default_nettype none
// ----------------------------------------------------------------------------
// srrb_engine: recovery decision engine
// Holds the supervisor state and works out one event per cycle while fire is high.
// ----------------------------------------------------------------------------
module srrb_engine (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               fire,
    input  wire srrb_pkg::item_t    item,
    input  wire srrb_pkg::cfg_t     cfg,
    output srrb_pkg::result_t       res
);

    logic [7:0]  attempt_count_reg,     attempt_count_next;
    logic [63:0] next_attempt_time_reg, next_attempt_time_next;
    logic [63:0] settle_end_time_reg,   settle_end_time_next;
    logic [63:0] on_since_time_reg,     on_since_time_next;
    logic        waiting_enable_reg,    waiting_enable_next;
    logic        waiting_disable_reg,   waiting_disable_next;
    logic        desktop_seen_reg,      desktop_seen_next;
    logic        reload_owed_reg,       reload_owed_next;
    logic        was_on_reg,            was_on_next;
    logic        tracking_on_reg,       tracking_on_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attempt_count_reg     <= '0;
            next_attempt_time_reg <= '0;
            settle_end_time_reg   <= '0;
            on_since_time_reg     <= '0;
            waiting_enable_reg    <= 1'b0;
            waiting_disable_reg   <= 1'b0;
            desktop_seen_reg      <= 1'b0;
            reload_owed_reg       <= 1'b0;
            was_on_reg            <= 1'b0;
            tracking_on_reg       <= 1'b0;
        end
        else if (fire)
        begin
            attempt_count_reg     <= attempt_count_next;
            next_attempt_time_reg <= next_attempt_time_next;
            settle_end_time_reg   <= settle_end_time_next;
            on_since_time_reg     <= on_since_time_next;
            waiting_enable_reg    <= waiting_enable_next;
            waiting_disable_reg   <= waiting_disable_next;
            desktop_seen_reg      <= desktop_seen_next;
            reload_owed_reg       <= reload_owed_next;
            was_on_reg            <= was_on_next;
            tracking_on_reg       <= tracking_on_next;
        end
    end

    // event decision
    always_comb
    begin
        logic        fresh;
        logic        use_fast;
        logic        stopped;
        logic        failed;
        logic [63:0] on_elapsed;

        attempt_count_next     = attempt_count_reg;
        next_attempt_time_next = next_attempt_time_reg;
        settle_end_time_next   = settle_end_time_reg;
        on_since_time_next     = on_since_time_reg;
        waiting_enable_next    = waiting_enable_reg;
        waiting_disable_next   = waiting_disable_reg;
        desktop_seen_next      = desktop_seen_reg;
        reload_owed_next       = reload_owed_reg;
        was_on_next            = was_on_reg;
        tracking_on_next       = tracking_on_reg;
        res.recovery_step      = srrb_pkg::STEP_WAIT;
        res.restart_needed     = 1'b0;
        fresh                  = 1'b0;
        use_fast               = 1'b0;
        stopped                = 1'b0;
        failed                 = 1'b0;
        on_elapsed             = '0;

        case (item.action)
            srrb_pkg::ACT_PRESENCE:
            begin
                if (!item.desktop_present)
                begin
                    // desktop gone: forget attempts, presence and on tracking; a reload is owed
                    desktop_seen_next      = 1'b0;
                    reload_owed_next       = 1'b1;
                    attempt_count_next     = '0;
                    next_attempt_time_next = '0;
                    waiting_enable_next    = 1'b0;
                    waiting_disable_next   = 1'b0;
                    was_on_next            = 1'b0;
                    tracking_on_next       = 1'b0;
                end
                else
                begin
                    // appeared or session changed: open a settle window
                    if (!desktop_seen_reg || item.session_changed)
                    begin
                        fresh                = !desktop_seen_reg;
                        desktop_seen_next    = 1'b1;
                        reload_owed_next     = 1'b1;
                        settle_end_time_next = item.now + {32'd0, cfg.settle_time};
                        tracking_on_next     = 1'b0;
                        if (fresh)
                        begin
                            attempt_count_next     = '0;
                            next_attempt_time_next = '0;
                            waiting_enable_next    = 1'b0;
                            waiting_disable_next   = 1'b0;
                        end
                    end
                    if (item.now < settle_end_time_next)
                        res.recovery_step = srrb_pkg::STEP_WAIT;
                    else if (reload_owed_next)
                    begin
                        reload_owed_next  = 1'b0;
                        res.recovery_step = srrb_pkg::STEP_RELOAD;
                    end
                    else
                        res.recovery_step = srrb_pkg::STEP_POLL;
                end
            end

            srrb_pkg::ACT_ATTEMPT:
            begin
                // count up to the fast limit, then back off
                if (attempt_count_reg < cfg.fast_attempt_limit)
                    attempt_count_next = attempt_count_reg + 8'd1;
                use_fast = attempt_count_next < cfg.fast_attempt_limit;
                next_attempt_time_next = item.now + {32'd0, use_fast ?
                                         cfg.fast_retry_delay : cfg.slow_retry_delay};
                waiting_enable_next  = item.enable_requested;
                waiting_disable_next = !item.enable_requested;
            end

            srrb_pkg::ACT_OBSERVE:
            begin
                if (item.service_status == srrb_pkg::STATUS_ON)
                begin
                    was_on_next = 1'b1;
                    if (!tracking_on_reg)
                    begin
                        tracking_on_next   = 1'b1;
                        on_since_time_next = item.now;
                    end
                    on_elapsed = item.now - on_since_time_next;
                    // stably on: attempts no longer needed
                    if (!waiting_disable_reg && on_elapsed >= {32'd0, cfg.stable_time})
                    begin
                        attempt_count_next     = '0;
                        next_attempt_time_next = '0;
                        waiting_enable_next    = 1'b0;
                        waiting_disable_next   = 1'b0;
                    end
                end
                else if (item.service_status == srrb_pkg::STATUS_OFF)
                begin
                    stopped = was_on_reg && !waiting_disable_reg;
                    failed  = waiting_enable_reg && (item.now >= next_attempt_time_reg);
                    was_on_next      = 1'b0;
                    tracking_on_next = 1'b0;
                    if (waiting_disable_reg)
                    begin
                        attempt_count_next     = '0;
                        next_attempt_time_next = '0;
                        waiting_enable_next    = 1'b0;
                        waiting_disable_next   = 1'b0;
                    end
                    res.restart_needed = stopped || failed;
                end
                else
                    // unknown, and the unused code
                    tracking_on_next = 1'b0;
            end

            default: ;
        endcase

        res.attempt_due = desktop_seen_next && (item.now >= settle_end_time_next)
                          && (item.now >= next_attempt_time_next);
    end

    // checks
    a_absent_clears: assert property (@(posedge clk) disable iff (!rst_n)
        fire && item.action == srrb_pkg::ACT_PRESENCE && !item.desktop_present
        |=> !desktop_seen_reg && attempt_count_reg == 8'd0 && !tracking_on_reg)
        else $error("absent desktop did not clear supervisor state");

    a_attempt_waits: assert property (@(posedge clk) disable iff (!rst_n)
        fire && item.action == srrb_pkg::ACT_ATTEMPT
        |=> waiting_enable_reg != waiting_disable_reg)
        else $error("recorded attempt left no single pending direction");

    a_wait_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !(waiting_enable_reg && waiting_disable_reg))
        else $error("waiting for enable and disable at once");

    a_hold_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !fire |=> $stable(attempt_count_reg) && $stable(next_attempt_time_reg))
        else $error("state moved without an event");

endmodule
`default_nettype wire

FILE: rtl/session_recovery_retry_backoff_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// session_recovery_retry_backoff_core: recording service recovery supervisor
// Input register, decision engine and result register behind an APB port.
// ----------------------------------------------------------------------------
// One event word is taken every clock cycle unless the result side stalls: the
// event is captured in an input register, the engine updates all supervisor
// state and forms the result as the word advances, and the result sits in an
// output register until taken. The rate is set by the engine's combinational
// state update (a 64-bit time add feeding 64-bit compares); a stalled result
// holds one further event in the input register.
// ----------------------------------------------------------------------------
module session_recovery_retry_backoff_core (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [srrb_pkg::CFG_ADDR_W-1:0]    paddr,
    input  wire logic [srrb_pkg::CFG_DATA_W-1:0]    pwdata,
    output logic      [srrb_pkg::CFG_DATA_W-1:0]    prdata,
    output logic                                    pready,
    srrb_in_if.sink                                 in_ch,
    srrb_out_if.source                              out_ch
);

    srrb_pkg::cfg_t     cfg;
    srrb_pkg::item_t    in_item_reg;
    srrb_pkg::result_t  out_res_reg;
    srrb_pkg::result_t  res;
    logic               in_valid_reg;
    logic               out_valid_reg;
    logic               advance;
    logic               in_take;

    srrb_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // handshake
    assign advance     = in_valid_reg && (!out_valid_reg || out_ch.ready);
    assign in_ch.ready = !in_valid_reg || advance;
    assign in_take     = in_ch.valid && in_ch.ready;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_take)
            in_valid_reg <= 1'b1;
        else if (advance)
            in_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_item_reg.action           <= in_ch.action;
            in_item_reg.now              <= in_ch.now;
            in_item_reg.desktop_present  <= in_ch.desktop_present;
            in_item_reg.session_changed  <= in_ch.session_changed;
            in_item_reg.enable_requested <= in_ch.enable_requested;
            in_item_reg.service_status   <= in_ch.service_status;
        end
    end

    srrb_engine u_engine (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (advance),
        .item  (in_item_reg),
        .cfg   (cfg),
        .res   (res)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (out_ch.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            out_res_reg <= res;
    end

    assign out_ch.valid          = out_valid_reg;
    assign out_ch.recovery_step  = out_res_reg.recovery_step;
    assign out_ch.restart_needed = out_res_reg.restart_needed;
    assign out_ch.attempt_due    = out_res_reg.attempt_due;

    // checks
    a_word_moves: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !out_valid_reg |=> out_valid_reg)
        else $error("held event word did not reach the result register");

    a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ch.ready |=> out_valid_reg && $stable(out_res_reg))
        else $error("stalled result word lost or changed");

    a_full_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && out_valid_reg && !out_ch.ready |-> !in_ch.ready)
        else $error("event word taken with both stages full");

endmodule
`default_nettype wire

FILE: dv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the session recovery supervisor
// Drives timestamped events through the valid/ready event channel, predicts
// every result word with an in-bench model of the supervisor state, and
// compares each word taken from the result channel, field by field, against
// the oldest prediction. Registers are reprogrammed over APB between phases.
// ----------------------------------------------------------------------------
module tb_top;
    import srrb_pkg::*;

    // spare codes that the block must still handle
    localparam logic [1:0] ACT_SPARE    = 2'd3;
    localparam logic [1:0] STATUS_SPARE = 2'd3;

    localparam logic [63:0] TIME_MAX   = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam int          IDLE_GUARD = 6;

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    srrb_in_if  ev_ch ();
    srrb_out_if res_ch ();

    session_recovery_retry_backoff_core u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .in_ch   (ev_ch),
        .out_ch  (res_ch)
    );

    // register shadow and supervisor state as the bench sees it
    cfg_t        knobs;
    logic [7:0]  fast_tries;
    logic [63:0] retry_at;
    logic [63:0] settle_until;
    logic [63:0] on_start;
    logic        expect_enable;
    logic        expect_disable;
    logic        desktop_up;
    logic        reload_pending;
    logic        service_was_on;
    logic        on_timing;

    result_t     verdicts_due[$];
    result_t     oldest_verdict;
    int          fail_count = 0;
    int unsigned gap_pct    = 0;
    int unsigned stall_pct  = 0;
    logic [63:0] clock_ms   = 64'd0;

    // ------------------------------------------------------------------
    // Supervisor prediction
    // ------------------------------------------------------------------
    function automatic void forget_attempts();
        fast_tries     = 8'd0;
        retry_at       = 64'd0;
        expect_enable  = 1'b0;
        expect_disable = 1'b0;
    endfunction

    function automatic void reset_supervisor();
        knobs.settle_time        = RST_SETTLE_TIME;
        knobs.fast_attempt_limit = RST_FAST_LIMIT;
        knobs.fast_retry_delay   = RST_FAST_DELAY;
        knobs.slow_retry_delay   = RST_SLOW_DELAY;
        knobs.stable_time        = RST_STABLE_TIME;
        forget_attempts();
        settle_until   = 64'd0;
        on_start       = 64'd0;
        desktop_up     = 1'b0;
        reload_pending = 1'b0;
        service_was_on = 1'b0;
        on_timing      = 1'b0;
    endfunction

    // applies one event to the state and returns the verdict word
    function automatic result_t supervise_event(input item_t ev);
        result_t r;
        logic    fresh;
        logic    stopped;
        logic    failed;
        r = '0;
        case (ev.action)
            ACT_PRESENCE:
            begin
                if (!ev.desktop_present)
                begin
                    desktop_up     = 1'b0;
                    reload_pending = 1'b1;
                    forget_attempts();
                    service_was_on = 1'b0;
                    on_timing      = 1'b0;
                    r.recovery_step = STEP_WAIT;
                end
                else
                begin
                    // appearance or session change opens a new settle window
                    if (!desktop_up || ev.session_changed)
                    begin
                        fresh          = !desktop_up;
                        desktop_up     = 1'b1;
                        reload_pending = 1'b1;
                        settle_until   = ev.now + {32'd0, knobs.settle_time};
                        on_timing      = 1'b0;
                        if (fresh)
                            forget_attempts();
                    end
                    if (ev.now < settle_until)
                        r.recovery_step = STEP_WAIT;
                    else if (reload_pending)
                    begin
                        reload_pending  = 1'b0;
                        r.recovery_step = STEP_RELOAD;
                    end
                    else
                        r.recovery_step = STEP_POLL;
                end
            end
            ACT_ATTEMPT:
            begin
                // count stops at the fast limit and holds if the limit is lowered below it
                if (fast_tries < knobs.fast_attempt_limit)
                    fast_tries = fast_tries + 8'd1;
                retry_at = ev.now + ((fast_tries < knobs.fast_attempt_limit)
                                     ? {32'd0, knobs.fast_retry_delay}
                                     : {32'd0, knobs.slow_retry_delay});
                expect_enable  = ev.enable_requested;
                expect_disable = !ev.enable_requested;
            end
            ACT_OBSERVE:
            begin
                if (ev.service_status == STATUS_ON)
                begin
                    service_was_on = 1'b1;
                    if (!on_timing)
                    begin
                        on_timing = 1'b1;
                        on_start  = ev.now;
                    end
                    if (!expect_disable
                        && (ev.now - on_start) >= {32'd0, knobs.stable_time})
                        forget_attempts();
                end
                else if (ev.service_status == STATUS_OFF)
                begin
                    stopped        = service_was_on && !expect_disable;
                    failed         = expect_enable && (ev.now >= retry_at);
                    service_was_on = 1'b0;
                    on_timing      = 1'b0;
                    if (expect_disable)
                        forget_attempts();
                    r.restart_needed = stopped || failed;
                end
                else
                    on_timing = 1'b0;   // unknown and the spare code alike
            end
            default: ;
        endcase
        r.attempt_due = desktop_up && (ev.now >= settle_until) && (ev.now >= retry_at);
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Clock, reset and watchdog
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #1500000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // ------------------------------------------------------------------
    // Result side: random back-pressure and the word checker
    // ------------------------------------------------------------------
    initial
    begin : stall_gen
        res_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct)
            begin
                res_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge clk);
            end
            res_ch.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (verdicts_due.size() == 0)
            begin
                fail_count++;
                $display("%0t: result word with none expected: step %0d restart %0d due %0d",
                         $time, res_ch.recovery_step, res_ch.restart_needed,
                         res_ch.attempt_due);
            end
            else
            begin
                oldest_verdict = verdicts_due.pop_front();
                if (res_ch.recovery_step !== oldest_verdict.recovery_step)
                begin
                    fail_count++;
                    $display("%0t: recovery_step expected %0d actual %0d", $time,
                             oldest_verdict.recovery_step, res_ch.recovery_step);
                end
                if (res_ch.restart_needed !== oldest_verdict.restart_needed)
                begin
                    fail_count++;
                    $display("%0t: restart_needed expected %0d actual %0d", $time,
                             oldest_verdict.restart_needed, res_ch.restart_needed);
                end
                if (res_ch.attempt_due !== oldest_verdict.attempt_due)
                begin
                    fail_count++;
                    $display("%0t: attempt_due expected %0d actual %0d", $time,
                             oldest_verdict.attempt_due, res_ch.attempt_due);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Shared drivers
    // ------------------------------------------------------------------
    // one event word, with an optional idle burst in front
    task automatic send_event(input item_t ev);
        if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct)
        begin
            ev_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
        ev_ch.valid            <= 1'b1;
        ev_ch.action           <= ev.action;
        ev_ch.now              <= ev.now;
        ev_ch.desktop_present  <= ev.desktop_present;
        ev_ch.session_changed  <= ev.session_changed;
        ev_ch.enable_requested <= ev.enable_requested;
        ev_ch.service_status   <= ev.service_status;
        @(posedge clk);
        while (!ev_ch.ready) @(posedge clk);
        verdicts_due.push_back(supervise_event(ev));
    endtask

    function automatic item_t compose_event(input logic [1:0] action, input logic [63:0] now,
                                            input logic present, input logic changed,
                                            input logic enable, input logic [1:0] status);
        item_t ev;
        ev.action           = action;
        ev.now              = now;
        ev.desktop_present  = present;
        ev.session_changed  = changed;
        ev.enable_requested = enable;
        ev.service_status   = status;
        return ev;
    endfunction

    // stop sending and let every outstanding word drain
    task automatic wait_for_idle();
        ev_ch.valid <= 1'b0;
        while (verdicts_due.size() != 0) @(posedge clk);
        repeat (IDLE_GUARD) @(posedge clk);
    endtask

    // APB write: setup cycle, then access cycle until pready
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_SETTLE_TIME: knobs.settle_time        = value;
            REG_FAST_LIMIT:  knobs.fast_attempt_limit = value[7:0];
            REG_FAST_DELAY:  knobs.fast_retry_delay   = value;
            REG_SLOW_DELAY:  knobs.slow_retry_delay   = value;
            REG_STABLE_TIME: knobs.stable_time        = value;
            default: ;
        endcase
    endtask

    task automatic apply_settings(input logic [31:0] settle, input logic [7:0] limit,
                                  input logic [31:0] fast, input logic [31:0] slow,
                                  input logic [31:0] stable);
        wait_for_idle();
        write_reg(REG_SETTLE_TIME, settle);
        // junk in the upper bits of the 8-bit limit must be dropped
        write_reg(REG_FAST_LIMIT, {24'($urandom()), limit});
        write_reg(REG_FAST_DELAY, fast);
        write_reg(REG_SLOW_DELAY, slow);
        write_reg(REG_STABLE_TIME, stable);
    endtask

    // mostly plausible sessions; times are often aimed at the live deadlines
    function automatic item_t random_event();
        item_t       ev;
        int unsigned roll;
        roll = $urandom_range(0, 99);
        ev = '0;
        ev.desktop_present  = ($urandom_range(0, 99) >= 8);
        ev.session_changed  = ($urandom_range(0, 99) < 12);
        ev.enable_requested = ($urandom_range(0, 3) != 0);
        case ($urandom_range(0, 9))
            0, 1, 2, 3: ev.service_status = STATUS_ON;
            4, 5, 6:    ev.service_status = STATUS_OFF;
            7, 8:       ev.service_status = STATUS_UNKNOWN;
            default:    ev.service_status = STATUS_SPARE;
        endcase
        if (roll < 4)
            ev.action = ACT_SPARE;
        else if (roll < (desktop_up ? 30 : 80))
            ev.action = ACT_PRESENCE;
        else if (roll < (desktop_up ? 55 : 90))
            ev.action = ACT_ATTEMPT;
        else
            ev.action = ACT_OBSERVE;
        case ($urandom_range(0, 11))
            0: clock_ms = {$urandom(), $urandom()};
            1: clock_ms = settle_until + 64'($urandom_range(0, 2)) - 64'd1;
            2: clock_ms = retry_at + 64'($urandom_range(0, 2)) - 64'd1;
            3: clock_ms = on_start + {32'd0, knobs.stable_time}
                          + 64'($urandom_range(0, 2)) - 64'd1;
            4: clock_ms = TIME_MAX - 64'($urandom_range(0, 50));
            5:
            begin
                case ($urandom_range(0, 3))
                    0:       clock_ms += {32'd0, knobs.settle_time};
                    1:       clock_ms += {32'd0, knobs.fast_retry_delay};
                    2:       clock_ms += {32'd0, knobs.slow_retry_delay};
                    default: clock_ms += {32'd0, knobs.stable_time};
                endcase
            end
            6:       ;
            7, 8:    clock_ms += 64'($urandom_range(1, 64));
            default: clock_ms += 64'($urandom_range(1, 3000));
        endcase
        ev.now = clock_ms;
        return ev;
    endfunction

    task automatic run_traffic(input int count, input int unsigned gaps,
                               input int unsigned stalls);
        gap_pct   = gaps;
        stall_pct = stalls;
        repeat (count) send_event(random_event());
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // reset settings: each event kind, field extremes, time wrap, spare codes
    task automatic test_reset_defaults();
        gap_pct   = 15;
        stall_pct = 15;
        send_event(compose_event(ACT_PRESENCE, 64'd0, 1'b0, 1'b0, 1'b0, STATUS_UNKNOWN));
        send_event(compose_event(ACT_SPARE, TIME_MAX, 1'b1, 1'b1, 1'b1, STATUS_SPARE));
        send_event(compose_event(ACT_OBSERVE, 64'd5, 1'b0, 1'b0, 1'b0, STATUS_SPARE));
        // desktop appears; wait, edge of window, reload, poll, session change
        send_event(compose_event(ACT_PRESENCE, 64'd100, 1'b1, 1'b0, 1'b0, STATUS_UNKNOWN));
        send_event(compose_event(ACT_PRESENCE, 64'd3099, 1'b1, 1'b0, 1'b0, STATUS_UNKNOWN));
        send_event(compose_event(ACT_PRESENCE, 64'd3100, 1'b1, 1'b0, 1'b0, STATUS_UNKNOWN));
        send_event(compose_event(ACT_PRESENCE, 64'd3200, 1'b1, 1'b0, 1'b0, STATUS_UNKNOWN));
        send_event(compose_event(ACT_PRESENCE, 64'd3300, 1'b1, 1'b1, 1'b0, STATUS_UNKNOWN));
        // fast attempts up to the limit, then the slow delay
        send_event(compose_event(ACT_ATTEMPT, 64'd6300, 1'b0, 1'b0, 1'b1, STATUS_UNKNOWN));
        send_event(compose_event(ACT_ATTEMPT, 64'd6400, 1'b0, 1'b0, 1'b1, STATUS_UNKNOWN));
        send_event(compose_event(ACT_ATTEMPT, 64'd6500, 1'b0, 1'b0, 1'b1, STATUS_UNKNOWN));
        // failed enable, then stable on clears attempts
        send_event(compose_event(ACT_OBSERVE, 64'd70000, 1'b0, 1'b0, 1'b0, STATUS_OFF));
        send_event(compose_event(ACT_OBSERVE, 64'd70100, 1'b0, 1'b0, 1'b0, STATUS_ON));
        send_event(compose_event(ACT_OBSERVE, 64'd80100, 1'b0, 1'b0, 1'b0, STATUS_ON));
        // requested disable: no clear while on, no restart when off
        send_event(compose_event(ACT_ATTEMPT, 64'd80200, 1'b0, 1'b0, 1'b0, STATUS_UNKNOWN));
        send_event(compose_event(ACT_OBSERVE, 64'd90000, 1'b0, 1'b0, 1'b0, STATUS_ON));
        send_event(compose_event(ACT_OBSERVE, 64'd90100, 1'b0, 1'b0, 1'b0, STATUS_OFF));
        // unexpected stop
        send_event(compose_event(ACT_OBSERVE, 64'd90200, 1'b0, 1'b0, 1'b0, STATUS_ON));
        send_event(compose_event(ACT_OBSERVE, 64'd90300, 1'b0, 1'b0, 1'b0, STATUS_UNKNOWN));
        send_event(compose_event(ACT_OBSERVE, 64'd90400, 1'b0, 1'b0, 1'b0, STATUS_OFF));
        // settle end and retry time both wrap past the top of the time range
        send_event(compose_event(ACT_PRESENCE, TIME_MAX - 64'd100, 1'b1, 1'b1, 1'b0,
                                 STATUS_UNKNOWN));
        send_event(compose_event(ACT_ATTEMPT, TIME_MAX, 1'b0, 1'b0, 1'b1, STATUS_UNKNOWN));
    endtask

    // limit lowered below the count already reached: count holds, slow delay
    task automatic test_lowered_fast_limit();
        wait_for_idle();
        write_reg(REG_FAST_LIMIT, 32'd6);
        repeat (3)
            send_event(compose_event(ACT_ATTEMPT, 64'd500, 1'b0, 1'b0, 1'b1, STATUS_ON));
        wait_for_idle();
        write_reg(REG_FAST_LIMIT, 32'd2);
        send_event(compose_event(ACT_ATTEMPT, 64'd600, 1'b0, 1'b0, 1'b1, STATUS_ON));
        send_event(compose_event(ACT_OBSERVE, 64'd700, 1'b0, 1'b0, 1'b0, STATUS_OFF));
    endtask

    task automatic test_random_traffic();
        apply_settings(RST_SETTLE_TIME, RST_FAST_LIMIT, RST_FAST_DELAY, RST_SLOW_DELAY,
                       RST_STABLE_TIME);
        run_traffic(90, 20, 20);
        apply_settings(32'd5, 8'd4, 32'd10, 32'd40, 32'd20);
        run_traffic(50, 30, 0);
        // sender holds off until every outstanding word is back
        wait_for_idle();
        run_traffic(50, 30, 0);
        // lowered limit with attempts likely still counted
        apply_settings(32'd5, 8'd1, 32'd10, 32'd40, 32'd20);
        run_traffic(80, 0, 30);
        apply_settings($urandom_range(0, 100), 8'($urandom_range(0, 8)),
                       $urandom_range(0, 200), $urandom_range(0, 2000),
                       $urandom_range(0, 500));
        run_traffic(100, 15, 15);
    endtask

    task automatic test_config_extremes();
        apply_settings(32'd0, 8'd0, 32'd0, 32'd0, 32'd0);
        run_traffic(80, 10, 10);
        apply_settings(32'hFFFF_FFFF, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        run_traffic(90, 25, 25);
    endtask

    // full rate on both sides to close the run
    task automatic test_quiet_tail();
        apply_settings(32'd12, 8'd2, 32'd3, 32'd7, 32'd0);
        run_traffic(110, 0, 0);
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial
    begin : run_all
        rst_n                  <= 1'b0;
        psel                   <= 1'b0;
        penable                <= 1'b0;
        pwrite                 <= 1'b0;
        paddr                  <= '0;
        pwdata                 <= '0;
        ev_ch.valid            <= 1'b0;
        ev_ch.action           <= ACT_PRESENCE;
        ev_ch.now              <= 64'd0;
        ev_ch.desktop_present  <= 1'b0;
        ev_ch.session_changed  <= 1'b0;
        ev_ch.enable_requested <= 1'b0;
        ev_ch.service_status   <= STATUS_UNKNOWN;
        reset_supervisor();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_lowered_fast_limit();
        test_random_traffic();
        test_config_extremes();
        test_quiet_tail();

        wait_for_idle();
        if (fail_count == 0 && verdicts_due.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
